// ===== rtl/core/mcg_pkg.sv =====
// mcg_pkg: shared types and constants of the metronome click generator
// config record, controller states, datapath command and status records
// no dependencies
package mcg_pkg;

	localparam int VOICES_DEF          = 4;
	localparam int SINE_TABLE_BITS_DEF = 10;
	localparam int SAMPLE_BITS_DEF     = 24;

	// position * 256 as an unsigned 72 bit numerator
	localparam int BDIV_W         = 72;
	localparam int DIVISOR_W      = 32;
	// width of the rounded click magnitude before the ramp division
	localparam int MAG_W          = 55;
	localparam int DEN_SHIFT_BASE = 44;
	localparam int ACC_EXTRA      = 16;

	localparam logic [15:0] SIN_A = 16'd51472;
	localparam logic [15:0] SIN_B = 16'd21023;
	localparam logic [15:0] SIN_C = 16'd2320;

	localparam logic [14:0] ACCENT_DOWN = 15'd22938;
	localparam logic [14:0] ACCENT_BEAT = 15'd16384;

	localparam logic [31:0] MIN_PERIOD = 32'd256;
	localparam logic [9:0]  MIN_LENGTH = 10'd4;

	localparam logic [31:0] RST_BEAT_PERIOD   = 32'd6144000;
	localparam logic [4:0]  RST_BEATS_PER_BAR = 5'd4;
	localparam logic [15:0] RST_CLICK_GAIN    = 16'd16384;
	localparam logic [9:0]  RST_CLICK_LENGTH  = 10'd240;
	localparam logic [31:0] RST_DOWN_STEP     = 32'd107374182;
	localparam logic [31:0] RST_BEAT_STEP     = 32'd78741067;

	typedef enum logic [2:0] {
		REG_ENABLE,
		REG_POLY_MODE,
		REG_BEAT_PERIOD,
		REG_BEATS_PER_BAR,
		REG_CLICK_GAIN,
		REG_CLICK_LENGTH,
		REG_DOWN_STEP,
		REG_BEAT_STEP
	} cfg_reg_t;

	typedef struct packed {
		logic        enable;
		logic        poly_mode;
		logic [31:0] beat_period;
		logic [4:0]  beats_per_bar;
		logic [15:0] click_gain;
		logic [9:0]  click_length;
		logic [31:0] downbeat_phase_step;
		logic [31:0] beat_phase_step;
	} cfg_t;

	typedef enum logic [2:0] {
		MS_PHASE,
		MS_X2,
		MS_T1,
		MS_U,
		MS_Y,
		MS_SG,
		MS_AN,
		MS_MAG
	} mul_sel_t;

	typedef enum logic [3:0] {
		CS_IDLE,
		CS_SETUP,
		CS_BDIV,
		CS_BMOD,
		CS_TRIG,
		CS_SLOT,
		CS_MUL,
		CS_RLOAD,
		CS_RDIV,
		CS_RACC,
		CS_OUT
	} ctrl_state_t;

	typedef struct packed {
		logic     in_load;
		logic     clear_seed;
		logic     bdiv_load;
		logic     rdiv_load;
		logic     div_step;
		logic     mod_track;
		logic     trigger;
		logic     retire;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     accum;
		logic     out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic pass;
		logic short_period;
		logic rolling;
		logic do_beat;
		logic slot_active;
		logic slot_stale;
		logic out_free;
	} dp_stat_t;

endpackage

// ===== rtl/core/mcg_div.sv =====
// mcg_div: restoring divider, one quotient bit per step
// dividend shifts out at the top while quotient bits shift in at the bottom
// depends on nothing
module mcg_div #(
	parameter int NUM_W = 72,
	parameter int DEN_W = 32
) (
	input  logic             clk,
	input  logic             load,
	input  logic             step,
	input  logic [NUM_W-1:0] num_in,
	input  logic [DEN_W-1:0] den_in,
	output logic [NUM_W-1:0] quot
);

	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             ge;

	assign trial = {rem_q, num_q[NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};
	assign quot  = num_q;

	always_ff @(posedge clk) begin
		if (load) begin
			num_q <= num_in;
			rem_q <= '0;
			den_q <= den_in;
		end else if (step) begin
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			num_q <= {num_q[NUM_W-2:0], ge};
		end
	end

endmodule

// ===== rtl/core/mcg_dp.sv =====
// mcg_dp: datapath of the click generator, beat tracking, voices, sine, mixing
// uses mcg_pkg and mcg_div; driven by commands from mcg_ctrl
module mcg_dp #(
	parameter int VOICES          = mcg_pkg::VOICES_DEF,
	parameter int SINE_TABLE_BITS = mcg_pkg::SINE_TABLE_BITS_DEF,
	parameter int SAMPLE_BITS     = mcg_pkg::SAMPLE_BITS_DEF,
	localparam int SW             = $clog2(VOICES + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mcg_pkg::cfg_t                 cfg,
	input  mcg_pkg::dp_cmd_t              cmd,
	input  logic [SW-1:0]                 sidx,
	output mcg_pkg::dp_stat_t             stat,
	input  logic signed [63:0]            sample_position,
	input  logic                          transport_rolling,
	input  logic                          force_enable,
	input  logic signed [SAMPLE_BITS-1:0] left_in,
	input  logic signed [SAMPLE_BITS-1:0] right_in,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic signed [SAMPLE_BITS-1:0] left_out,
	output logic signed [SAMPLE_BITS-1:0] right_out
);

	localparam int NVW     = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int SB      = SAMPLE_BITS;
	localparam int SH      = mcg_pkg::DEN_SHIFT_BASE - SAMPLE_BITS;
	localparam int TW      = mcg_pkg::MAG_W - SH;
	localparam int ACC_W   = SAMPLE_BITS + mcg_pkg::ACC_EXTRA;
	localparam int PH_LOW  = 32 - SINE_TABLE_BITS;
	localparam int BDIV_WL = mcg_pkg::BDIV_W;
	localparam logic [31:0] PH_MASK = ~((32'd1 << PH_LOW) - 32'd1);

	// latched input beat
	logic [63:0]   pos_q;
	logic          rolling_q;
	logic          force_q;
	logic [SB-1:0] left_q;
	logic [SB-1:0] right_q;

	// slot state
	logic [VOICES-1:0] voice_act_q;
	logic [9:0]        voice_pos_q  [VOICES];
	logic [9:0]        voice_len_q  [VOICES];
	logic              voice_down_q [VOICES];
	logic              mono_act_q;
	logic [9:0]        mono_pos_q;
	logic              mono_down_q;
	logic [NVW-1:0]    nv_q;
	logic [63:0]       last_beat_q;
	logic              seeded_q;

	// arithmetic
	logic [31:0]      phase_q;
	logic [15:0]      x2_q;
	logic [11:0]      t1_q;
	logic [14:0]      u_q;
	logic [14:0]      y_q;
	logic [30:0]      sg_q;
	logic [22:0]      an_q;
	logic [53:0]      mag_q;
	logic [ACC_W-1:0] acc_q;
	logic [4:0]       md_q;
	logic             modstep_q;
	logic             out_valid_q;
	logic [SB-1:0]    left_out_q;
	logic [SB-1:0]    right_out_q;

	logic [9:0]  eff_len;
	logic [4:0]  bpb_eff;
	logic        eff;
	logic        is_mono;
	logic [NVW-1:0] vidx;
	logic        sl_act;
	logic [9:0]  sl_pos;
	logic [9:0]  sl_len;
	logic        sl_down;
	logic [9:0]  pos_inc;
	logic [7:0]  r_c;
	logic [9:0]  len_m_r;
	logic [9:0]  rem_len;
	logic [7:0]  n_c;
	logic [31:0] ph_m;
	logic [15:0] x_c;
	logic        neg_c;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] prod;
	logic [16:0] y_raw;

	logic [BDIV_WL-1:0]        beat_num;
	logic [BDIV_WL-1:0]        rend_num;
	logic [BDIV_WL-1:0]        quot;
	logic [mcg_pkg::MAG_W-1:0] rnd_sum;
	logic [63:0]               beat_c;
	logic                      down_c;
	logic                      fire;
	logic [NVW-1:0]            nv_next;
	logic [5:0]                mod_trial;
	logic [ACC_W-1:0]          q_ext;
	logic [ACC_W-1:0]          contrib;
	logic [ACC_W:0]            sum_l;
	logic [ACC_W:0]            sum_r;

	function automatic logic [SB-1:0] sat(input logic [ACC_W:0] v);
		logic ovf;
		ovf = (v[ACC_W:SB-1] != '0) && (v[ACC_W:SB-1] != '1);
		if (!ovf)
			return v[SB-1:0];
		return v[ACC_W] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}};
	endfunction

	assign eff_len = (cfg.click_length < mcg_pkg::MIN_LENGTH) ? mcg_pkg::MIN_LENGTH
		: cfg.click_length;
	assign bpb_eff = (cfg.beats_per_bar == 5'd0) ? 5'd1 : cfg.beats_per_bar;
	assign eff     = force_q | cfg.enable;

	assign stat.pass         = !eff && !(mono_act_q || (|voice_act_q));
	assign stat.short_period = cfg.beat_period < mcg_pkg::MIN_PERIOD;
	assign stat.rolling      = rolling_q;
	assign stat.do_beat      = rolling_q && eff;
	assign stat.out_free     = !out_valid_q || out_ready;

	// slot selected by the controller, the last index is the mono slot
	assign is_mono = sidx == SW'(VOICES);
	assign vidx    = is_mono ? '0 : sidx[NVW-1:0];
	assign sl_act  = is_mono ? mono_act_q  : voice_act_q[vidx];
	assign sl_pos  = is_mono ? mono_pos_q  : voice_pos_q[vidx];
	assign sl_len  = is_mono ? eff_len     : voice_len_q[vidx];
	assign sl_down = is_mono ? mono_down_q : voice_down_q[vidx];
	assign pos_inc = sl_pos + 10'd1;

	assign stat.slot_active = sl_act;
	assign stat.slot_stale  = sl_pos >= sl_len;

	// envelope: ramp length and numerator
	assign r_c     = (sl_len[9:2] == 8'd0) ? 8'd1 : sl_len[9:2];
	assign len_m_r = sl_len - 10'(r_c);
	assign rem_len = sl_len - sl_pos;
	always_comb begin
		if (sl_pos < 10'(r_c))
			n_c = sl_pos[7:0];
		else if (sl_pos > len_m_r)
			n_c = rem_len[7:0];
		else
			n_c = r_c;
	end

	// quarter wave argument from the table bits of the phase
	assign ph_m  = phase_q & PH_MASK;
	assign x_c   = ph_m[30] ? (16'd32768 - {1'b0, ph_m[29:15]}) : {1'b0, ph_m[29:15]};
	assign neg_c = phase_q[31];

	always_comb begin
		case (cmd.mul_sel)
			mcg_pkg::MS_PHASE: begin
				mul_a = 32'(sl_pos);
				mul_b = sl_down ? cfg.downbeat_phase_step : cfg.beat_phase_step;
			end
			mcg_pkg::MS_X2: begin
				mul_a = 32'(x_c);
				mul_b = 32'(x_c);
			end
			mcg_pkg::MS_T1: begin
				mul_a = 32'(x2_q);
				mul_b = 32'(mcg_pkg::SIN_C);
			end
			mcg_pkg::MS_U: begin
				mul_a = 32'(x2_q);
				mul_b = 32'(mcg_pkg::SIN_B - 16'(t1_q));
			end
			mcg_pkg::MS_Y: begin
				mul_a = 32'(x_c);
				mul_b = 32'(mcg_pkg::SIN_A - 16'(u_q));
			end
			mcg_pkg::MS_SG: begin
				mul_a = 32'(y_q);
				mul_b = 32'(cfg.click_gain);
			end
			mcg_pkg::MS_AN: begin
				mul_a = 32'(sl_down ? mcg_pkg::ACCENT_DOWN : mcg_pkg::ACCENT_BEAT);
				mul_b = 32'(n_c);
			end
			mcg_pkg::MS_MAG: begin
				mul_a = 32'(sg_q);
				mul_b = 32'(an_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod  = mul_a * mul_b;
	assign y_raw = prod[31:15];

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			case (cmd.mul_sel)
				mcg_pkg::MS_PHASE: phase_q <= prod[31:0];
				mcg_pkg::MS_X2:    x2_q    <= prod[30:15];
				mcg_pkg::MS_T1:    t1_q    <= prod[26:15];
				mcg_pkg::MS_U:     u_q     <= prod[29:15];
				mcg_pkg::MS_Y:     y_q     <= (y_raw > 17'd32767) ? 15'h7fff : y_raw[14:0];
				mcg_pkg::MS_SG:    sg_q    <= prod[30:0];
				mcg_pkg::MS_AN:    an_q    <= prod[22:0];
				mcg_pkg::MS_MAG:   mag_q   <= prod[53:0];
				default: ;
			endcase
		end
	end

	// floor division numerators: beat uses one's complement for negative positions
	assign beat_num = pos_q[63] ? ~{pos_q, 8'h00} : {pos_q, 8'h00};
	assign rnd_sum  = {1'b0, mag_q} + (mcg_pkg::MAG_W'(r_c) << (SH - 1));
	assign rend_num = {rnd_sum[mcg_pkg::MAG_W-1:SH], {(BDIV_WL-TW){1'b0}}};

	mcg_div #(
		.NUM_W(BDIV_WL),
		.DEN_W(mcg_pkg::DIVISOR_W)
	) u_div (
		.clk   (clk),
		.load  (cmd.bdiv_load | cmd.rdiv_load),
		.step  (cmd.div_step),
		.num_in(cmd.bdiv_load ? beat_num : rend_num),
		.den_in(cmd.bdiv_load ? cfg.beat_period : mcg_pkg::DIVISOR_W'(r_c)),
		.quot  (quot)
	);

	assign beat_c    = pos_q[63] ? ~quot[63:0] : quot[63:0];
	assign down_c    = pos_q[63] ? (md_q == bpb_eff - 5'd1) : (md_q == 5'd0);
	assign mod_trial = {md_q, quot[0]};
	assign fire      = cmd.trigger && seeded_q && (beat_c != last_beat_q);
	assign nv_next   = (nv_q == NVW'(VOICES - 1)) ? '0 : nv_q + 1'b1;

	assign q_ext   = ACC_W'(quot[TW-1:0]);
	assign contrib = neg_c ? (~q_ext + 1'b1) : q_ext;
	assign sum_l   = {acc_q[ACC_W-1], acc_q} + {{(ACC_W+1-SB){left_q[SB-1]}}, left_q};
	assign sum_r   = {acc_q[ACC_W-1], acc_q} + {{(ACC_W+1-SB){right_q[SB-1]}}, right_q};

	always_ff @(posedge clk) begin
		if (cmd.in_load) begin
			pos_q     <= sample_position;
			rolling_q <= transport_rolling;
			force_q   <= force_enable;
			left_q    <= left_in;
			right_q   <= right_in;
			acc_q     <= '0;
		end else if (cmd.accum) begin
			acc_q <= acc_q + contrib;
		end
		// each quotient bit joins the bar position in the cycle after it is shifted in
		if (cmd.bdiv_load)
			md_q <= '0;
		else if (modstep_q)
			md_q <= (mod_trial >= {1'b0, bpb_eff}) ? 5'(mod_trial - {1'b0, bpb_eff})
				: mod_trial[4:0];
		if (fire && cfg.poly_mode) begin
			voice_pos_q[nv_q]  <= '0;
			voice_len_q[nv_q]  <= eff_len;
			voice_down_q[nv_q] <= down_c;
		end
		if (fire && !cfg.poly_mode) begin
			mono_pos_q  <= '0;
			mono_down_q <= down_c;
		end
		if (cmd.accum) begin
			if (is_mono)
				mono_pos_q <= pos_inc;
			else
				voice_pos_q[vidx] <= pos_inc;
		end
		if (cmd.out_load) begin
			left_out_q  <= sat(sum_l);
			right_out_q <= sat(sum_r);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			voice_act_q <= '0;
			mono_act_q  <= 1'b0;
			nv_q        <= '0;
			last_beat_q <= {1'b1, 63'd0};
			seeded_q    <= 1'b0;
			modstep_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			modstep_q   <= cmd.div_step & cmd.mod_track;
			out_valid_q <= cmd.out_load | (out_valid_q & ~out_ready);
			if (cmd.clear_seed)
				seeded_q <= 1'b0;
			if (cmd.trigger) begin
				last_beat_q <= beat_c;
				seeded_q    <= 1'b1;
			end
			if (fire) begin
				if (cfg.poly_mode) begin
					voice_act_q[nv_q] <= 1'b1;
					nv_q              <= nv_next;
					mono_act_q        <= 1'b0;
				end else begin
					mono_act_q  <= 1'b1;
					voice_act_q <= '0;
				end
			end
			if (cmd.retire || (cmd.accum && (pos_inc >= sl_len))) begin
				if (is_mono)
					mono_act_q <= 1'b0;
				else
					voice_act_q[vidx] <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign left_out  = left_out_q;
	assign right_out = right_out_q;

	// voice 0, while live, never sits at or past its own length
	a_voice_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		voice_act_q[0] |-> voice_pos_q[0] < voice_len_q[0])
		else $error("voice 0 active beyond its length");

	// seeding is only dropped by a stopped transport
	a_seed_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(seeded_q) |-> $past(cmd.clear_seed))
		else $error("beat seeding lost without transport stop");

	// a click start never coincides with a slot update
	a_trig_excl: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.trigger |-> !cmd.accum && !cmd.retire)
		else $error("trigger overlaps slot render");

endmodule

// ===== rtl/core/mcg_ctrl.sv =====
// mcg_ctrl: sequencer of the click generator
// walks beat division, trigger, per slot multiply chain and ramp division
// uses mcg_pkg; drives mcg_dp through dp_cmd_t, reads dp_stat_t
module mcg_ctrl #(
	parameter int VOICES      = mcg_pkg::VOICES_DEF,
	parameter int SAMPLE_BITS = mcg_pkg::SAMPLE_BITS_DEF,
	localparam int SW         = $clog2(VOICES + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  mcg_pkg::dp_stat_t stat,
	output mcg_pkg::dp_cmd_t  cmd,
	output logic [SW-1:0]     sidx
);

	localparam int RDIV_STEPS = mcg_pkg::MAG_W - (mcg_pkg::DEN_SHIFT_BASE - SAMPLE_BITS);
	localparam int CNT_W      = $clog2(mcg_pkg::BDIV_W);

	mcg_pkg::ctrl_state_t state_q, state_d;
	logic [CNT_W-1:0]     cnt_q, cnt_d;
	logic [SW-1:0]        sidx_q, sidx_d;
	mcg_pkg::mul_sel_t    mstep_q, mstep_d;
	logic                 last_slot;

	assign last_slot = sidx_q == SW'(VOICES);
	assign sidx      = sidx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mcg_pkg::CS_IDLE;
			cnt_q   <= '0;
			sidx_q  <= '0;
			mstep_q <= mcg_pkg::MS_PHASE;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			sidx_q  <= sidx_d;
			mstep_q <= mstep_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q;
		sidx_d      = sidx_q;
		mstep_d     = mstep_q;
		cmd         = '0;
		cmd.mul_sel = mstep_q;
		in_ready    = 1'b0;
		case (state_q)
			mcg_pkg::CS_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.in_load = 1'b1;
					state_d     = mcg_pkg::CS_SETUP;
				end
			end
			mcg_pkg::CS_SETUP: begin
				sidx_d = '0;
				cnt_d  = '0;
				if (stat.pass) begin
					state_d = mcg_pkg::CS_OUT;
				end else begin
					cmd.clear_seed = !stat.rolling;
					if (stat.short_period) begin
						state_d = mcg_pkg::CS_OUT;
					end else if (stat.do_beat) begin
						cmd.bdiv_load = 1'b1;
						state_d       = mcg_pkg::CS_BDIV;
					end else begin
						state_d = mcg_pkg::CS_SLOT;
					end
				end
			end
			mcg_pkg::CS_BDIV: begin
				cmd.div_step  = 1'b1;
				cmd.mod_track = 1'b1;
				if (cnt_q == CNT_W'(mcg_pkg::BDIV_W - 1)) begin
					cnt_d   = '0;
					state_d = mcg_pkg::CS_BMOD;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			mcg_pkg::CS_BMOD: begin
				// bar position takes the last quotient bit here
				state_d = mcg_pkg::CS_TRIG;
			end
			mcg_pkg::CS_TRIG: begin
				cmd.trigger = 1'b1;
				state_d     = mcg_pkg::CS_SLOT;
			end
			mcg_pkg::CS_SLOT: begin
				if (!stat.slot_active || stat.slot_stale) begin
					cmd.retire = stat.slot_active;
					if (last_slot)
						state_d = mcg_pkg::CS_OUT;
					else
						sidx_d = sidx_q + 1'b1;
				end else begin
					mstep_d = mcg_pkg::MS_PHASE;
					state_d = mcg_pkg::CS_MUL;
				end
			end
			mcg_pkg::CS_MUL: begin
				cmd.mul_en = 1'b1;
				if (mstep_q == mcg_pkg::MS_MAG)
					state_d = mcg_pkg::CS_RLOAD;
				else
					mstep_d = mcg_pkg::mul_sel_t'(mstep_q + 3'd1);
			end
			mcg_pkg::CS_RLOAD: begin
				cmd.rdiv_load = 1'b1;
				cnt_d         = '0;
				state_d       = mcg_pkg::CS_RDIV;
			end
			mcg_pkg::CS_RDIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == CNT_W'(RDIV_STEPS - 1)) begin
					cnt_d   = '0;
					state_d = mcg_pkg::CS_RACC;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			mcg_pkg::CS_RACC: begin
				cmd.accum = 1'b1;
				if (last_slot)
					state_d = mcg_pkg::CS_OUT;
				else begin
					sidx_d  = sidx_q + 1'b1;
					state_d = mcg_pkg::CS_SLOT;
				end
			end
			mcg_pkg::CS_OUT: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = mcg_pkg::CS_IDLE;
				end
			end
			default: begin
				state_d = mcg_pkg::CS_IDLE;
			end
		endcase
	end

	a_accept_setup: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == mcg_pkg::CS_SETUP)
		else $error("accepted beat not followed by setup");

	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> stat.out_free)
		else $error("result written over a waiting result");

	a_rdiv_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == mcg_pkg::CS_RDIV |-> cnt_q < CNT_W'(RDIV_STEPS))
		else $error("ramp division overran");

endmodule

// ===== rtl/core/metronome_click_generator_core.sv =====
// metronome_click_generator_core: top level, config registers and the two halves
// uses mcg_pkg, mcg_ctrl, mcg_dp (which holds mcg_div)
//
//   port group   dir   handshake             payload
//   in           in    in_valid / in_ready   sample_position, transport_rolling,
//                                            force_enable, left_in, right_in
//   out          out   out_valid / out_ready left_out, right_out
//   cfg          in    cfg_valid / cfg_ready cfg_index, cfg_data
//
// one beat in flight: setup, then (when the beat index is computed) beat division,
//   bar position and trigger, then a check of each of the VOICES + 1 slots with
//   multiply chain, ramp division and accumulation per sounding slot, then output
// one restoring divider gives the 72 bit beat quotient and every ramp quotient
// a finished result waits in the output register while the next beat is accepted
// cfg_ready is always high; reset clears config to defaults and silences all voices
module metronome_click_generator_core #(
	parameter int VOICES          = mcg_pkg::VOICES_DEF,
	parameter int SINE_TABLE_BITS = mcg_pkg::SINE_TABLE_BITS_DEF,
	parameter int SAMPLE_BITS     = mcg_pkg::SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [63:0]            sample_position,
	input  logic                          transport_rolling,
	input  logic                          force_enable,
	input  logic signed [SAMPLE_BITS-1:0] left_in,
	input  logic signed [SAMPLE_BITS-1:0] right_in,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] left_out,
	output logic signed [SAMPLE_BITS-1:0] right_out,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [2:0]                    cfg_index,
	input  logic [31:0]                   cfg_data
);

	localparam int SW = $clog2(VOICES + 1);

	mcg_pkg::cfg_t     cfg_q;
	mcg_pkg::dp_cmd_t  cmd;
	mcg_pkg::dp_stat_t stat;
	logic [SW-1:0]     sidx;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable              <= 1'b0;
			cfg_q.poly_mode           <= 1'b0;
			cfg_q.beat_period         <= mcg_pkg::RST_BEAT_PERIOD;
			cfg_q.beats_per_bar       <= mcg_pkg::RST_BEATS_PER_BAR;
			cfg_q.click_gain          <= mcg_pkg::RST_CLICK_GAIN;
			cfg_q.click_length        <= mcg_pkg::RST_CLICK_LENGTH;
			cfg_q.downbeat_phase_step <= mcg_pkg::RST_DOWN_STEP;
			cfg_q.beat_phase_step     <= mcg_pkg::RST_BEAT_STEP;
		end else if (cfg_valid && cfg_ready) begin
			case (mcg_pkg::cfg_reg_t'(cfg_index))
				mcg_pkg::REG_ENABLE:        cfg_q.enable              <= cfg_data[0];
				mcg_pkg::REG_POLY_MODE:     cfg_q.poly_mode           <= cfg_data[0];
				mcg_pkg::REG_BEAT_PERIOD:   cfg_q.beat_period         <= cfg_data;
				mcg_pkg::REG_BEATS_PER_BAR: cfg_q.beats_per_bar       <= cfg_data[4:0];
				mcg_pkg::REG_CLICK_GAIN:    cfg_q.click_gain          <= cfg_data[15:0];
				mcg_pkg::REG_CLICK_LENGTH:  cfg_q.click_length        <= cfg_data[9:0];
				mcg_pkg::REG_DOWN_STEP:     cfg_q.downbeat_phase_step <= cfg_data;
				mcg_pkg::REG_BEAT_STEP:     cfg_q.beat_phase_step     <= cfg_data;
				default: ;
			endcase
		end
	end

	mcg_ctrl #(
		.VOICES     (VOICES),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.stat    (stat),
		.cmd     (cmd),
		.sidx    (sidx)
	);

	mcg_dp #(
		.VOICES         (VOICES),
		.SINE_TABLE_BITS(SINE_TABLE_BITS),
		.SAMPLE_BITS    (SAMPLE_BITS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg_q),
		.cmd              (cmd),
		.sidx             (sidx),
		.stat             (stat),
		.sample_position  (sample_position),
		.transport_rolling(transport_rolling),
		.force_enable     (force_enable),
		.left_in          (left_in),
		.right_in         (right_in),
		.out_ready        (out_ready),
		.out_valid        (out_valid),
		.left_out         (left_out),
		.right_out        (right_out)
	);

endmodule
